// ----- sv/i2ctp_pkg.sv -----
// Shared types and constants of the two-sensor I2C polling master.
package i2ctp_pkg;

  // One bus phase as it enters the block.
  typedef struct packed {
    logic period_tick;
    logic sda_level;
  } in_item_t;

  // One result beat: line drives plus an optional finished reading.
  typedef struct packed {
    logic              scl_pull_low;
    logic              sda_pull_low;
    logic              reading_valid;
    logic              sensor_number;
    logic signed [7:0] temp_degrees;
    logic [1:0]        temp_quarters;
    logic              slave_acked;
  } out_item_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_POLL_PERIOD  = 2'd0;
  localparam logic [1:0] REG_SENSOR_A     = 2'd1;
  localparam logic [1:0] REG_SENSOR_B     = 2'd2;
  localparam logic [1:0] REG_SETUP_BYTE   = 2'd3;

  // Register reset values.
  localparam logic [7:0] POLL_PERIOD_RST  = 8'd100;
  localparam logic [6:0] SENSOR_A_RST     = 7'h49;
  localparam logic [6:0] SENSOR_B_RST     = 7'h4A;
  localparam logic [7:0] SETUP_BYTE_RST   = 8'h40;

  // Sensor register numbers used by the start-up writes.
  localparam logic [7:0] SENSOR_CFG_REG   = 8'h01;
  localparam logic [7:0] SENSOR_TEMP_REG  = 8'h00;

endpackage

// ----- sv/i2ctp_inq.sv -----
// Two-entry input queue that decouples the item source from the bus sequencer.
module i2ctp_inq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  i2ctp_pkg::in_item_t push_item,
  input  logic                take,
  output logic                avail,
  output i2ctp_pkg::in_item_t head_item
);
  import i2ctp_pkg::*;

  in_item_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_take;

  assign full      = (count == 2'd2);
  assign avail     = (count != 2'd0);
  assign head_item = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_take   = take && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_take};
    end
  end

  a_inq_count: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("input queue count out of range");

endmodule

// ----- sv/i2ctp_seq.sv -----
// Bus sequencer: runs start-up writes, the poll timer and the sensor reads, one phase a beat.
module i2ctp_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_avail,
  input  i2ctp_pkg::in_item_t  in_item,
  output logic                 in_take,
  input  logic                 out_room,
  output logic                 out_write,
  output i2ctp_pkg::out_item_t out_item
);
  import i2ctp_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_TXL   = 4'd2;
  localparam logic [3:0] ST_TXH   = 4'd3;
  localparam logic [3:0] ST_AIL   = 4'd4;
  localparam logic [3:0] ST_AIH   = 4'd5;
  localparam logic [3:0] ST_RXL   = 4'd6;
  localparam logic [3:0] ST_RXH   = 4'd7;
  localparam logic [3:0] ST_AOL   = 4'd8;
  localparam logic [3:0] ST_AOH   = 4'd9;
  localparam logic [3:0] ST_SPL   = 4'd10;
  localparam logic [3:0] ST_SPH   = 4'd11;
  localparam logic [3:0] ST_SPE   = 4'd12;
  localparam logic [3:0] ST_BAD   = 4'd15;

  localparam logic [2:0] XF_WR_A_CFG = 3'd0;
  localparam logic [2:0] XF_WR_A_PTR = 3'd1;
  localparam logic [2:0] XF_WR_B_CFG = 3'd2;
  localparam logic [2:0] XF_WR_B_PTR = 3'd3;
  localparam logic [2:0] XF_IDLE     = 3'd4;
  localparam logic [2:0] XF_READ_A   = 3'd5;
  localparam logic [2:0] XF_READ_B   = 3'd6;

  // Configuration registers.
  logic [7:0] poll_period;
  logic [6:0] sensor_a_address;
  logic [6:0] sensor_b_address;
  logic [7:0] sensor_setup_byte;

  // Sequencer state.
  logic [3:0] step, step_next;
  logic [1:0] bidx, bidx_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] xf, xf_next;
  logic [7:0] degrees_hold, degrees_hold_next;
  logic       ack_hold, ack_hold_next;
  logic [7:0] period_count, period_count_next;

  logic       fire;
  logic       rd;
  logic       busy_ok;
  logic [3:0] eff_step;
  logic [8:0] count_inc;
  logic [2:0] bidx_inc;
  logic [2:0] nbytes;
  logic [3:0] bc_inc;
  logic [7:0] rx_shift;
  out_item_t  res;

  // Byte to send for a transfer at a given byte position.
  function automatic logic [7:0] byte_for(input logic [2:0] x, input logic [2:0] idx,
                                          input logic [6:0] addr_a, input logic [6:0] addr_b,
                                          input logic [7:0] setup);
    logic [6:0] addr;
    logic [7:0] b;
    addr = (x == XF_WR_B_CFG || x == XF_WR_B_PTR || x == XF_READ_B) ? addr_b : addr_a;
    if (idx == 3'd0) begin
      b = {addr, (x >= XF_READ_A)};
    end else if (x == XF_WR_A_PTR || x == XF_WR_B_PTR) begin
      b = SENSOR_TEMP_REG;
    end else if (idx == 3'd1) begin
      b = SENSOR_CFG_REG;
    end else begin
      b = setup;
    end
    return b;
  endfunction

  assign fire      = in_avail && out_room;
  assign in_take   = fire;
  assign out_write = fire;
  assign out_item  = res;

  assign rd        = (xf == XF_READ_A) || (xf == XF_READ_B);
  assign busy_ok   = (xf <= XF_WR_B_PTR) || rd;
  assign eff_step  = (step != ST_IDLE && !busy_ok) ? ST_BAD : step;
  assign count_inc = {1'b0, period_count} + 9'd1;
  assign bidx_inc  = {1'b0, bidx} + 3'd1;
  assign nbytes    = (xf == XF_WR_A_PTR || xf == XF_WR_B_PTR) ? 3'd2 : 3'd3;
  assign bc_inc    = bit_count + 4'd1;
  assign rx_shift  = {shift_byte[6:0], in_item.sda_level};

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_period       <= POLL_PERIOD_RST;
      sensor_a_address  <= SENSOR_A_RST;
      sensor_b_address  <= SENSOR_B_RST;
      sensor_setup_byte <= SETUP_BYTE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POLL_PERIOD: poll_period       <= cfg_data;
        REG_SENSOR_A:    sensor_a_address  <= cfg_data[6:0];
        REG_SENSOR_B:    sensor_b_address  <= cfg_data[6:0];
        REG_SETUP_BYTE:  sensor_setup_byte <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    step_next         = step;
    bidx_next         = bidx;
    bit_count_next    = bit_count;
    shift_byte_next   = shift_byte;
    xf_next           = xf;
    degrees_hold_next = degrees_hold;
    ack_hold_next     = ack_hold;
    period_count_next = period_count;
    res               = '0;

    case (eff_step)
      ST_IDLE: begin
        if (xf != XF_IDLE) begin
          xf_next = XF_IDLE;
        end else if (in_item.period_tick) begin
          if (count_inc >= {1'b0, poll_period}) begin
            period_count_next = 8'd0;
            xf_next           = XF_READ_A;
            bidx_next         = 2'd0;
            step_next         = ST_START;
          end else begin
            period_count_next = count_inc[7:0];
          end
        end
      end
      ST_START: begin
        res.sda_pull_low = 1'b1;
        shift_byte_next  = byte_for(xf, 3'd0, sensor_a_address, sensor_b_address,
                                    sensor_setup_byte);
        bit_count_next   = 4'd0;
        bidx_next        = 2'd0;
        step_next        = ST_TXL;
      end
      ST_TXL, ST_TXH: begin
        res.scl_pull_low = (eff_step == ST_TXL);
        res.sda_pull_low = ~shift_byte[7];
        if (eff_step == ST_TXL) begin
          step_next = ST_TXH;
        end else begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          if (bc_inc >= 4'd8) begin
            bit_count_next = 4'd0;
            step_next      = ST_AIL;
          end else begin
            bit_count_next = bc_inc;
            step_next      = ST_TXL;
          end
        end
      end
      ST_AIL: begin
        res.scl_pull_low = 1'b1;
        step_next        = ST_AIH;
      end
      ST_AIH: begin
        if (bidx == 2'd0) begin
          ack_hold_next = ~in_item.sda_level;
        end
        if (rd) begin
          bit_count_next = 4'd0;
          bidx_next      = 2'd1;
          step_next      = ST_RXL;
        end else if (bidx_inc < nbytes) begin
          shift_byte_next = byte_for(xf, bidx_inc, sensor_a_address, sensor_b_address,
                                     sensor_setup_byte);
          bit_count_next  = 4'd0;
          bidx_next       = bidx_inc[1:0];
          step_next       = ST_TXL;
        end else begin
          bidx_next = 2'd0;
          step_next = ST_SPL;
        end
      end
      ST_RXL: begin
        res.scl_pull_low = 1'b1;
        step_next        = ST_RXH;
      end
      ST_RXH: begin
        shift_byte_next = rx_shift;
        if (bc_inc >= 4'd8) begin
          bit_count_next = 4'd0;
          if (bidx == 2'd1) begin
            degrees_hold_next = rx_shift;
          end
          step_next = ST_AOL;
        end else begin
          bit_count_next = bc_inc;
          step_next      = ST_RXL;
        end
      end
      ST_AOL, ST_AOH: begin
        res.scl_pull_low = (eff_step == ST_AOL);
        res.sda_pull_low = (bidx == 2'd1);
        if (eff_step == ST_AOL) begin
          step_next = ST_AOH;
        end else if (bidx == 2'd1) begin
          bidx_next = 2'd2;
          step_next = ST_RXL;
        end else begin
          bidx_next = 2'd0;
          step_next = ST_SPL;
        end
      end
      ST_SPL: begin
        res.scl_pull_low = 1'b1;
        res.sda_pull_low = 1'b1;
        bidx_next        = 2'd0;
        step_next        = ST_SPH;
      end
      ST_SPH: begin
        res.sda_pull_low = 1'b1;
        bidx_next        = 2'd0;
        step_next        = ST_SPE;
      end
      ST_SPE: begin
        if (rd) begin
          res.reading_valid = 1'b1;
          res.sensor_number = (xf == XF_READ_B);
          res.temp_degrees  = degrees_hold;
          res.temp_quarters = shift_byte[7:6];
          res.slave_acked   = ack_hold;
        end
        bidx_next = 2'd0;
        if (xf <= XF_WR_B_CFG || xf == XF_READ_A) begin
          xf_next   = xf + 3'd1;
          step_next = ST_START;
        end else begin
          xf_next   = XF_IDLE;
          step_next = ST_IDLE;
        end
        bit_count_next = 4'd0;
      end
      default: begin
        xf_next        = XF_IDLE;
        bidx_next      = 2'd0;
        step_next      = ST_IDLE;
        bit_count_next = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_START;
      bidx         <= 2'd0;
      bit_count    <= 4'd0;
      shift_byte   <= 8'd0;
      xf           <= XF_WR_A_CFG;
      degrees_hold <= 8'd0;
      ack_hold     <= 1'b0;
      period_count <= 8'd0;
    end else if (fire) begin
      step         <= step_next;
      bidx         <= bidx_next;
      bit_count    <= bit_count_next;
      shift_byte   <= shift_byte_next;
      xf           <= xf_next;
      degrees_hold <= degrees_hold_next;
      ack_hold     <= ack_hold_next;
      period_count <= period_count_next;
    end
  end

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst) bit_count <= 4'd8)
    else $error("bit counter passed eight");

  a_xf_legal: assert property (@(posedge clk) disable iff (rst) xf != 3'd7)
    else $error("transfer index took an unused code");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
      !fire |=> $stable(step) && $stable(xf) && $stable(bit_count))
    else $error("sequencer moved without a beat");

  a_reading_releases: assert property (@(posedge clk) disable iff (rst)
      fire && res.reading_valid |-> !res.scl_pull_low && !res.sda_pull_low)
    else $error("reading reported while a line is driven");

endmodule

// ----- sv/i2ctp_outq.sv -----
// Two-entry result queue between the sequencer and the result consumer.
module i2ctp_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 write,
  input  i2ctp_pkg::out_item_t write_item,
  output logic                 room,
  input  logic                 pop,
  output logic                 empty,
  output i2ctp_pkg::out_item_t head_item
);
  import i2ctp_pkg::*;

  out_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_write;
  logic       do_pop;

  assign room      = (count != 2'd2);
  assign empty     = (count == 2'd0);
  assign head_item = mem[rd_ptr];
  assign do_write  = write && room;
  assign do_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_ptr] <= write_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_write) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_write} - {1'b0, do_pop};
    end
  end

  a_outq_count: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("result queue count out of range");

endmodule

// ----- sv/i2c_temp_sensor_poller_top.sv -----
// Top level of the two-sensor I2C polling master.
//
// Each input beat is one bus phase: a sampled SDA level and a flag for an elapsed 10 ms period.
// Each input beat yields exactly one result beat carrying the open-drain drives for SCL and SDA,
// and on the last phase of a sensor read also the sensor number, the signed whole degrees, the
// quarter degrees and whether the sensor acknowledged its address. After reset the block writes
// the setup byte to register 1 of each sensor and points each sensor back at register 0, then
// counts periods and reads both sensors every poll_period periods. The block sustains one beat
// per clock while the input queue holds a beat and the result queue has room; the sequencer
// works out a phase combinationally, and its step sets the rate. A two-entry input queue and a
// two-entry result queue sit around it: a beat pushed is registered in the input queue, and the
// sequencer's result beat in the result queue, whose head drives the result ports until popped;
// either side may stall without holding up the other until its queue fills. Configuration writes
// are always ready; a new poll period applies to the next idle tick, and new addresses or a new
// setup byte apply to the next byte the sequencer loads. Write them only while the block is idle.
module i2c_temp_sensor_poller_top (
  input  logic              clk,
  input  logic              rst,
  // Input side.
  input  logic              push,
  output logic              full,
  input  logic              period_tick,
  input  logic              sda_level,
  // Result side.
  input  logic              pop,
  output logic              empty,
  output logic              scl_pull_low,
  output logic              sda_pull_low,
  output logic              reading_valid,
  output logic              sensor_number,
  output logic signed [7:0] temp_degrees,
  output logic [1:0]        temp_quarters,
  output logic              slave_acked,
  // Configuration write channel.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import i2ctp_pkg::*;

  in_item_t  push_item;
  in_item_t  head_in;
  logic      in_avail;
  logic      in_take;
  out_item_t seq_item;
  out_item_t head_out;
  logic      out_room;
  logic      out_write;

  // The register file accepts a write on every cycle.
  assign cfg_ready = 1'b1;

  assign push_item.period_tick = period_tick;
  assign push_item.sda_level   = sda_level;

  i2ctp_inq u_inq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .push_item (push_item),
    .take      (in_take),
    .avail     (in_avail),
    .head_item (head_in)
  );

  i2ctp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_avail  (in_avail),
    .in_item   (head_in),
    .in_take   (in_take),
    .out_room  (out_room),
    .out_write (out_write),
    .out_item  (seq_item)
  );

  i2ctp_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .write      (out_write),
    .write_item (seq_item),
    .room       (out_room),
    .pop        (pop),
    .empty      (empty),
    .head_item  (head_out)
  );

  // The result beat at the head of the queue drives the result ports.
  assign scl_pull_low  = head_out.scl_pull_low;
  assign sda_pull_low  = head_out.sda_pull_low;
  assign reading_valid = head_out.reading_valid;
  assign sensor_number = head_out.sensor_number;
  assign temp_degrees  = head_out.temp_degrees;
  assign temp_quarters = head_out.temp_quarters;
  assign slave_acked   = head_out.slave_acked;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the two-sensor I2C polling master, with a bus-phase predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2ctp_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 400000;
  // Queues inside the block are two entries deep, so this pause covers any beat still in flight.
  localparam int DRAIN_PAUSE = 6;

  // Sequencer steps of one bus phase, as the block walks through a transfer.
  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_START    = 4'd1,
    S_TX_LO    = 4'd2,
    S_TX_HI    = 4'd3,
    S_AIN_LO   = 4'd4,
    S_AIN_HI   = 4'd5,
    S_RX_LO    = 4'd6,
    S_RX_HI    = 4'd7,
    S_AOUT_LO  = 4'd8,
    S_AOUT_HI  = 4'd9,
    S_STOP_LO  = 4'd10,
    S_STOP_HI  = 4'd11,
    S_STOP_END = 4'd12,
    S_BAD      = 4'd15
  } bus_step_e;

  // Transfer numbers: four start-up writes, then idle, then one read per sensor.
  localparam logic [2:0] XFER_CFG_A  = 3'd0;
  localparam logic [2:0] XFER_PTR_A  = 3'd1;
  localparam logic [2:0] XFER_CFG_B  = 3'd2;
  localparam logic [2:0] XFER_PTR_B  = 3'd3;
  localparam logic [2:0] XFER_IDLE   = 3'd4;
  localparam logic [2:0] XFER_READ_A = 3'd5;
  localparam logic [2:0] XFER_READ_B = 3'd6;

  // How the sampled data line is shaped while filling a stimulus phase.
  typedef enum logic [1:0] {
    LINE_EVEN,
    LINE_MOSTLY_HIGH,
    LINE_MOSTLY_LOW
  } line_bias_e;

  // Clock, reset and every block input start at known values.
  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              push        = 1'b0;
  logic              period_tick = 1'b0;
  logic              sda_level   = 1'b0;
  logic              pop         = 1'b0;
  logic              cfg_valid   = 1'b0;
  logic [1:0]        cfg_index   = REG_POLL_PERIOD;
  logic [7:0]        cfg_data    = 8'd0;
  logic              full;
  logic              empty;
  logic              scl_pull_low;
  logic              sda_pull_low;
  logic              reading_valid;
  logic              sensor_number;
  logic signed [7:0] temp_degrees;
  logic [1:0]        temp_quarters;
  logic              slave_acked;
  logic              cfg_ready;

  i2c_temp_sensor_poller_top dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .period_tick   (period_tick),
    .sda_level     (sda_level),
    .pop           (pop),
    .empty         (empty),
    .scl_pull_low  (scl_pull_low),
    .sda_pull_low  (sda_pull_low),
    .reading_valid (reading_valid),
    .sensor_number (sensor_number),
    .temp_degrees  (temp_degrees),
    .temp_quarters (temp_quarters),
    .slave_acked   (slave_acked),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Bus phases waiting to be driven, and the line drives each accepted phase must produce.
  in_item_t  pending_phases[$];
  out_item_t expected_drives[$];

  // The predictor's copy of the configuration registers.
  logic [7:0] cfg_period;
  logic [6:0] cfg_addr_a;
  logic [6:0] cfg_addr_b;
  logic [7:0] cfg_setup;

  // The predictor's copy of the sequencer state.
  logic [7:0] ticks_counted;
  bus_step_e  step_q;
  logic [1:0] byte_q;
  logic [3:0] bits_q;
  logic [7:0] shift_q;
  logic [2:0] xfer_q;
  logic [7:0] degrees_q;
  logic       addr_ack_q;

  // Handshake history, bookkeeping and the running tallies for the summary.
  logic       in_taken  = 1'b0;
  logic       out_taken = 1'b0;
  logic       steady    = 1'b1;
  in_item_t   next_phase;
  out_item_t  predicted, oldest;
  int         push_hold = 0;
  int         pop_hold  = 0;
  int         fail_count = 0;
  int         beats_in = 0;
  int         beats_out = 0;
  int         readings = 0;
  int         readings_b = 0;
  int         readings_nack = 0;
  int         settings_done = 0;
  int         cycles = 0;

  task automatic reset_model();
    cfg_period    = POLL_PERIOD_RST;
    cfg_addr_a    = SENSOR_A_RST;
    cfg_addr_b    = SENSOR_B_RST;
    cfg_setup     = SETUP_BYTE_RST;
    ticks_counted = 8'd0;
    step_q        = S_START;
    byte_q        = 2'd0;
    bits_q        = 4'd0;
    shift_q       = 8'd0;
    xfer_q        = XFER_CFG_A;
    degrees_q     = 8'd0;
    addr_ack_q    = 1'b0;
  endtask

  // The byte a transfer sends at a given position, built from the registers of the moment.
  function automatic logic [7:0] byte_to_send(input logic [2:0] xf, input logic [1:0] idx);
    logic [6:0] addr;
    addr = (xf == XFER_CFG_B || xf == XFER_PTR_B || xf == XFER_READ_B) ? cfg_addr_b : cfg_addr_a;
    if (idx == 2'd0) return {addr, (xf >= XFER_READ_A)};
    if (xf == XFER_PTR_A || xf == XFER_PTR_B) return SENSOR_TEMP_REG;
    if (idx == 2'd1) return SENSOR_CFG_REG;
    return cfg_setup;
  endfunction

  // One bus phase of the sequencer: line drives out, and a reading on the last stop phase.
  task automatic advance_bus(input logic tick, input logic sda, output out_item_t res);
    bus_step_e  st;
    logic       rd;
    logic [8:0] next_cnt;
    int         byte_total;
    res = '0;
    rd = (xfer_q == XFER_READ_A || xfer_q == XFER_READ_B);
    byte_total = (xfer_q == XFER_PTR_A || xfer_q == XFER_PTR_B) ? 2 : 3;
    st = step_q;
    if (st != S_IDLE && !(xfer_q <= XFER_PTR_B || rd)) st = S_BAD;
    case (st)
      S_IDLE: begin
        // Ticks count only here; reaching the period (or passing a lowered one) starts a read.
        if (xfer_q != XFER_IDLE) begin
          xfer_q = XFER_IDLE;
        end else if (tick) begin
          next_cnt = {1'b0, ticks_counted} + 9'd1;
          if (next_cnt >= {1'b0, cfg_period}) begin
            ticks_counted = 8'd0;
            xfer_q = XFER_READ_A;
            byte_q = 2'd0;
            step_q = S_START;
          end else begin
            ticks_counted = next_cnt[7:0];
          end
        end
      end
      S_START: begin
        res.sda_pull_low = 1'b1;
        shift_q = byte_to_send(xfer_q, 2'd0);
        bits_q = 4'd0;
        byte_q = 2'd0;
        step_q = S_TX_LO;
      end
      S_TX_LO, S_TX_HI: begin
        res.scl_pull_low = (st == S_TX_LO);
        res.sda_pull_low = ~shift_q[7];
        if (st == S_TX_LO) begin
          step_q = S_TX_HI;
        end else begin
          shift_q = {shift_q[6:0], 1'b0};
          bits_q = bits_q + 4'd1;
          if (bits_q >= 4'd8) begin
            bits_q = 4'd0;
            step_q = S_AIN_LO;
          end else begin
            step_q = S_TX_LO;
          end
        end
      end
      S_AIN_LO: begin
        res.scl_pull_low = 1'b1;
        step_q = S_AIN_HI;
      end
      S_AIN_HI: begin
        // Only the address byte's acknowledge is kept; data-byte acknowledges are dropped.
        if (byte_q == 2'd0) addr_ack_q = ~sda;
        if (rd) begin
          bits_q = 4'd0;
          byte_q = 2'd1;
          step_q = S_RX_LO;
        end else if (int'(byte_q) + 1 < byte_total) begin
          shift_q = byte_to_send(xfer_q, byte_q + 2'd1);
          bits_q = 4'd0;
          byte_q = byte_q + 2'd1;
          step_q = S_TX_LO;
        end else begin
          byte_q = 2'd0;
          step_q = S_STOP_LO;
        end
      end
      S_RX_LO: begin
        res.scl_pull_low = 1'b1;
        step_q = S_RX_HI;
      end
      S_RX_HI: begin
        shift_q = {shift_q[6:0], sda};
        bits_q = bits_q + 4'd1;
        if (bits_q >= 4'd8) begin
          bits_q = 4'd0;
          if (byte_q == 2'd1) degrees_q = shift_q;
          step_q = S_AOUT_LO;
        end else begin
          step_q = S_RX_LO;
        end
      end
      S_AOUT_LO, S_AOUT_HI: begin
        // Acknowledge the first data byte, leave the line released after the second.
        res.scl_pull_low = (st == S_AOUT_LO);
        res.sda_pull_low = (byte_q == 2'd1);
        if (st == S_AOUT_LO) begin
          step_q = S_AOUT_HI;
        end else if (byte_q == 2'd1) begin
          byte_q = 2'd2;
          step_q = S_RX_LO;
        end else begin
          byte_q = 2'd0;
          step_q = S_STOP_LO;
        end
      end
      S_STOP_LO: begin
        res.scl_pull_low = 1'b1;
        res.sda_pull_low = 1'b1;
        byte_q = 2'd0;
        step_q = S_STOP_HI;
      end
      S_STOP_HI: begin
        res.sda_pull_low = 1'b1;
        step_q = S_STOP_END;
      end
      S_STOP_END: begin
        if (rd) begin
          res.reading_valid = 1'b1;
          res.sensor_number = (xfer_q == XFER_READ_B);
          res.temp_degrees  = degrees_q;
          res.temp_quarters = shift_q[7:6];
          res.slave_acked   = addr_ack_q;
        end
        if (xfer_q <= XFER_CFG_B || xfer_q == XFER_READ_A) begin
          xfer_q = xfer_q + 3'd1;
          step_q = S_START;
        end else begin
          xfer_q = XFER_IDLE;
          step_q = S_IDLE;
        end
        byte_q = 2'd0;
        bits_q = 4'd0;
      end
      default: begin
        // A state code the sequencer never uses falls back to idle with both lines released.
        xfer_q = XFER_IDLE;
        step_q = S_IDLE;
        byte_q = 2'd0;
        bits_q = 4'd0;
      end
    endcase
  endtask

  // Gap lengths in cycles: mostly none or short, now and then a long one.
  function automatic int draw_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic in_item_t random_phase(input int unsigned tick_pct, input line_bias_e bias);
    in_item_t it;
    it.period_tick = ($urandom_range(99, 0) < tick_pct);
    case (bias)
      LINE_MOSTLY_HIGH: it.sda_level = ($urandom_range(99, 0) < 92);
      LINE_MOSTLY_LOW:  it.sda_level = ($urandom_range(99, 0) < 8);
      default:          it.sda_level = $urandom_range(1, 0);
    endcase
    return it;
  endfunction

  // Input driver: a new phase goes out at the falling edge once the previous beat was taken.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      push_hold = 0;
    end else if (!push || in_taken) begin
      if (push_hold != 0) begin
        push <= 1'b0;
        push_hold--;
      end else if (pending_phases.size() != 0) begin
        next_phase = pending_phases.pop_front();
        push        <= 1'b1;
        period_tick <= next_phase.period_tick;
        sda_level   <= next_phase.sda_level;
        push_hold = draw_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result side: pop is held low for a random stretch after each beat it takes.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_hold = 0;
    end else begin
      if (out_taken) pop_hold = draw_gap();
      if (pop_hold != 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
    if (seen !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("Mismatch in %s at result beat %0d: expected %0h, got %0h",
                 name, beats_out, want, seen);
    end
  endtask

  // Monitor: every accepted input beat is predicted, every accepted result beat is checked
  // field by field against the oldest prediction still waiting.
  always @(posedge clk) begin
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= push && !full;
      out_taken <= pop && !empty;
      if (push && !full) begin
        advance_bus(period_tick, sda_level, predicted);
        expected_drives.push_back(predicted);
        beats_in++;
      end
      if (pop && !empty) begin
        if (expected_drives.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Result beat %0d arrived with no prediction waiting", beats_out);
        end else begin
          oldest = expected_drives.pop_front();
          check_field("scl_pull_low", oldest.scl_pull_low, scl_pull_low);
          check_field("sda_pull_low", oldest.sda_pull_low, sda_pull_low);
          check_field("reading_valid", oldest.reading_valid, reading_valid);
          check_field("sensor_number", oldest.sensor_number, sensor_number);
          check_field("temp_degrees", oldest.temp_degrees, temp_degrees);
          check_field("temp_quarters", oldest.temp_quarters, temp_quarters);
          check_field("slave_acked", oldest.slave_acked, slave_acked);
          if (oldest.reading_valid) begin
            readings++;
            if (oldest.sensor_number) readings_b++;
            if (!oldest.slave_acked) readings_nack++;
          end
        end
        beats_out++;
      end
    end
  end

  // Register writes go out at the falling edge and complete on the valid/ready handshake.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_POLL_PERIOD: cfg_period = val;
      REG_SENSOR_A:    cfg_addr_a = val[6:0];
      REG_SENSOR_B:    cfg_addr_b = val[6:0];
      default:         cfg_setup  = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input logic [7:0] period, input logic [6:0] addr_a,
                               input logic [6:0] addr_b, input logic [7:0] setup);
    write_reg(REG_POLL_PERIOD, period);
    write_reg(REG_SENSOR_A, {1'b0, addr_a});
    write_reg(REG_SENSOR_B, {1'b0, addr_b});
    write_reg(REG_SETUP_BYTE, setup);
    settings_done++;
  endtask

  // Waits until every queued phase went in and every predicted beat came out, then lets
  // the block settle so that a register write cannot overtake a beat still inside it.
  task automatic wait_drained();
    while (pending_phases.size() != 0 || push || expected_drives.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int unsigned tick_pct,
                           input line_bias_e bias, input logic no_gaps);
    steady = no_gaps;
    repeat (count) pending_phases.push_back(random_phase(tick_pct, bias));
    wait_drained();
  endtask

  initial begin
    reset_model();
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Start-up writes carry the setup byte and the addresses, so the extremes go in first:
    // address zero for the first sensor, all ones for the second, and a setup byte of all ones.
    apply_setting(8'd1, 7'd0, 7'd127, 8'hFF);

    // Directed beats at the start of the start-up writes: every combination of tick and data
    // level, so ticks arrive while the sequencer is busy and must be ignored.
    steady = 1'b1;
    for (int i = 0; i < 16; i++) begin
      next_phase.period_tick = i[0] ^ i[2];
      next_phase.sda_level   = i[1] ^ i[3];
      pending_phases.push_back(next_phase);
    end

    // Finish the start-up writes with gaps on both sides and get into the first reads.
    run_phase(250, 50, LINE_EVEN, 1'b0);

    // A zero period starts a read on the very first idle tick; data mostly high gives
    // unacknowledged addresses and readings near all ones.
    apply_setting(8'd0, 7'd127, 7'd0, 8'h00);
    run_phase(90, 40, LINE_MOSTLY_HIGH, 1'b0);

    // The largest period lets the tick count climb while nothing is read.
    apply_setting(8'd255, 7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)),
                  8'($urandom_range(255, 0)));
    run_phase(90, 90, LINE_EVEN, 1'b0);

    // Lowering the period under the count already reached must start a read on the next tick.
    apply_setting(8'd2, 7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)),
                  8'($urandom_range(255, 0)));
    run_phase(90, 50, LINE_MOSTLY_LOW, 1'b0);

    // A stretch without any idling on either side.
    apply_setting(8'($urandom_range(6, 1)), 7'($urandom_range(127, 0)),
                  7'($urandom_range(127, 0)), 8'($urandom_range(255, 0)));
    run_phase(90, 60, LINE_EVEN, 1'b1);

    apply_setting(8'd1, 7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)), 8'hA5);
    run_phase(90, 70, LINE_EVEN, 1'b0);

    $display("Drove %0d bus phases under %0d register settings, poll periods zero to maximum.",
             beats_in, settings_done);
    $display("Checked %0d beats with %0d readings (%0d second sensor, %0d unacked), %0d errors.",
             beats_out, readings, readings_b, readings_nack, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d predictions outstanding",
             cycles, expected_drives.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
